// ===== rtl/rs2si_pkg.sv =====
// ============================================================================
// rs2si_pkg: shared types and constants of the radix string parser
// Character codes, register indexes, the queue item format and the digit
// decoder that turns a character into its digit value.
// ============================================================================
`default_nettype none

package rs2si_pkg;

  // Configuration register indexes.
  localparam logic REG_RADIX       = 1'b0;
  localparam logic REG_SIGNED_MODE = 1'b1;

  // Register widths and reset values.
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned CFG_DATA_W  = RADIX_W;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic RADIX_SIGNED_RESET        = 1'b1;

  // Valid radix range.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  // Digit value given to a character that is not a digit at all.
  localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd36;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  // Saturation patterns.
  localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = {VALUE_W{1'b1}};
  localparam logic [VALUE_W-1:0] VALUE_INT_MIN  = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VALUE_INT_MAX  = {1'b0, {(VALUE_W-1){1'b1}}};

  // Queue depth between classifier and execution stage.
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = 1;
  localparam int unsigned QCOUNT_W = 2;

  // Configuration as seen by the execution stage.
  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
  } cfg_t;

  // One classified character.
  typedef struct packed {
    logic               term;
    logic               plus;
    logic               minus;
    logic [RADIX_W-1:0] digit;
  } qitem_t;

  // Digit value of a character: 0-9, letters 10-35, anything else 36.
  function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = CHAR_W'(DIGIT_NONE);
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      d = c - CHAR_ZERO;
    end else if (c inside {[CHAR_LC_A:CHAR_LC_Z]}) begin
      d = c - CHAR_LC_A + LETTER_OFS;
    end else if (c inside {[CHAR_UC_A:CHAR_UC_Z]}) begin
      d = c - CHAR_UC_A + LETTER_OFS;
    end
    return d[RADIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rs2si_if.sv =====
// ============================================================================
// rs2si_if: valid/ready channels of the radix string parser
// The character channel carries one input character per transfer, the value
// channel one parsed 64-bit result per transfer.
// ============================================================================
`default_nettype none

interface rs2si_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface rs2si_value_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rs2si_front.sv =====
// ============================================================================
// rs2si_front: character classifier
// Accepts characters and turns each into a queue item: terminator, sign
// flags and digit value.
// ============================================================================
`default_nettype none

module rs2si_front (
  rs2si_char_if.sink          in_ch,
  output logic                push_valid,
  output rs2si_pkg::qitem_t   push_item,
  input  logic                push_ready
);

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    push_item.term  = (in_ch.char_code == rs2si_pkg::CHAR_NUL);
    push_item.plus  = (in_ch.char_code == rs2si_pkg::CHAR_PLUS);
    push_item.minus = (in_ch.char_code == rs2si_pkg::CHAR_MINUS);
    push_item.digit = rs2si_pkg::digit_of(in_ch.char_code);
  end

endmodule

`default_nettype wire

// ===== rtl/rs2si_queue.sv =====
// ============================================================================
// rs2si_queue: two-entry item queue
// Decouples the classifier from the execution stage so that each side can
// stall on its own. Push and pop may happen in the same cycle.
// ============================================================================
`default_nettype none

module rs2si_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  rs2si_pkg::qitem_t   push_item,
  output logic                push_ready,
  output logic                pop_valid,
  output rs2si_pkg::qitem_t   pop_item,
  input  logic                pop_ready
);

  rs2si_pkg::qitem_t                       mem [rs2si_pkg::QDEPTH];
  logic [rs2si_pkg::QPTR_W-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [rs2si_pkg::QPTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [rs2si_pkg::QCOUNT_W-1:0]          count_r, count_nxt;
  logic                                    do_push, do_pop;

  assign push_ready = (count_r != rs2si_pkg::QCOUNT_W'(rs2si_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rs2si_back.sv =====
// ============================================================================
// rs2si_back: accumulator and result stage
// Applies one queued item per cycle to the parse state (a terminator waits
// for a free output register), runs the multiply-accumulate with overflow
// detection and formats the result into the output register on a terminator.
// ============================================================================
`default_nettype none

module rs2si_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rs2si_pkg::cfg_t     cfg,
  input  logic                pop_valid,
  input  rs2si_pkg::qitem_t   pop_item,
  output logic                pop_ready,
  rs2si_value_if.source       out_ch
);

  localparam int unsigned MAC_W = rs2si_pkg::VALUE_W + rs2si_pkg::RADIX_W;

  logic [rs2si_pkg::VALUE_W-1:0] acc_r, acc_nxt;
  logic                          first_r, first_nxt;
  logic                          neg_r, neg_nxt;
  logic                          stop_r, stop_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rs2si_pkg::VALUE_W-1:0] out_value_r;
  logic [rs2si_pkg::VALUE_W-1:0] final_value;
  logic [MAC_W-1:0]              mac;
  logic                          slot_free, do_pop, radix_ok;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign pop_ready = !pop_item.term || slot_free;
  assign do_pop    = pop_valid && pop_ready;

  assign out_ch.valid = out_valid_r;
  assign out_ch.value = out_value_r;

  // Narrow-by-wide multiply plus digit; any bit at 64 or above is an overflow.
  assign mac = MAC_W'(acc_r) * MAC_W'(cfg.radix) + MAC_W'(pop_item.digit);

  assign radix_ok = (cfg.radix >= rs2si_pkg::RADIX_MIN) &&
                    (cfg.radix <= rs2si_pkg::RADIX_MAX);

  always_comb begin
    final_value = acc_r;
    if (!radix_ok) begin
      final_value = '0;
    end else if (!cfg.signed_mode) begin
      final_value = ovf_r ? rs2si_pkg::VALUE_ALL_ONES : acc_r;
    end else if (neg_r) begin
      if (ovf_r || (acc_r > rs2si_pkg::VALUE_INT_MIN)) begin
        final_value = rs2si_pkg::VALUE_INT_MIN;
      end else begin
        final_value = '0 - acc_r;
      end
    end else if (ovf_r || acc_r[rs2si_pkg::VALUE_W-1]) begin
      final_value = rs2si_pkg::VALUE_INT_MAX;
    end
  end

  always_comb begin
    acc_nxt       = acc_r;
    first_nxt     = first_r;
    neg_nxt       = neg_r;
    stop_nxt      = stop_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (do_pop) begin
      if (pop_item.term) begin
        out_valid_nxt = 1'b1;
        acc_nxt       = '0;
        first_nxt     = 1'b1;
        neg_nxt       = 1'b0;
        stop_nxt      = 1'b0;
        ovf_nxt       = 1'b0;
      end else if (!stop_r) begin
        first_nxt = 1'b0;
        if (first_r && pop_item.plus) begin
          // A leading plus sign is simply consumed.
        end else if (first_r && pop_item.minus && cfg.signed_mode) begin
          neg_nxt = 1'b1;
        end else if (pop_item.digit >= cfg.radix) begin
          stop_nxt = 1'b1;
        end else if (mac[MAC_W-1:rs2si_pkg::VALUE_W] != '0) begin
          ovf_nxt  = 1'b1;
          stop_nxt = 1'b1;
        end else begin
          acc_nxt = mac[rs2si_pkg::VALUE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      first_r     <= 1'b1;
      neg_r       <= 1'b0;
      stop_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      first_r     <= first_nxt;
      neg_r       <= neg_nxt;
      stop_r      <= stop_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_item.term) begin
      out_value_r <= final_value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/radix_string_to_saturating_integer_core.sv =====
// ============================================================================
// radix_string_to_saturating_integer_core: streaming string-to-integer parser
// Parses a zero-terminated character string in a configurable radix into a
// saturated 64-bit signed or unsigned value, one character per transfer.
// ============================================================================
//
//   Channel  Direction  Payload             Transfers when
//   -------  ---------  ------------------  -----------------------------
//   in_ch    sink       char_code [7:0]     in_ch.valid && in_ch.ready
//   out_ch   source     value [63:0]        out_ch.valid && out_ch.ready
//   cfg      write      cfg_index, cfg_wdata  cfg_we (0: radix, 1: signed mode)
//
// The block takes one character per cycle while the queue has room. A
// terminator is written into the queue; when the execution stage pops it,
// its result enters the output register and can transfer out from there.
// The execution stage handles one queued character every cycle, unless a
// terminator waits for the output, with a single multiply-accumulate step.
// Reset is synchronous and active low; it clears the parse state and sets the
// radix to ten and signed mode on. A stalled output blocking a terminator
// fills the two-entry queue; input ready drops only once the queue is full.
//
`default_nettype none

module radix_string_to_saturating_integer_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  rs2si_char_if.sink                           in_ch,
  rs2si_value_if.source                        out_ch,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [rs2si_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Configuration registers. The user must write them only while no character is
  // in flight (the block does not enforce it); the execution stage reads them directly.
  logic [rs2si_pkg::RADIX_W-1:0] radix_r;
  logic                          signed_mode_r;
  rs2si_pkg::cfg_t               cfg;

  // Classified items between the front and the execution stage.
  logic                          push_valid, push_ready;
  rs2si_pkg::qitem_t             push_item;
  logic                          pop_valid, pop_ready;
  rs2si_pkg::qitem_t             pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r       <= rs2si_pkg::RADIX_RESET;
      signed_mode_r <= rs2si_pkg::RADIX_SIGNED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rs2si_pkg::REG_RADIX: begin
          radix_r <= cfg_wdata[rs2si_pkg::RADIX_W-1:0];
        end
        rs2si_pkg::REG_SIGNED_MODE: begin
          signed_mode_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.radix       = radix_r;
  assign cfg.signed_mode = signed_mode_r;

  // The front classifies each character as it is transferred.
  rs2si_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // A short queue lets the front keep accepting while a result waits.
  rs2si_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // The execution stage accumulates digits and produces the final value.
  rs2si_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/rs2si_checker.sv =====
// ============================================================================
// rs2si_checker: port-level checks of the radix string parser
// Watches the ports of the top level over time; attached by a bind.
// ============================================================================
`default_nettype none

module rs2si_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_value
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed or vanished while stalled");

  // No result is pending in the cycle after a reset edge.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An unstalled output keeps the queue draining, so input stays ready.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_ready) && $past(rst_n) |-> in_ready)
    else $error("input not ready although output was draining");

  // Input ready is high once nothing was offered and the output drained.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && out_ready |=> in_ready)
    else $error("input not ready after an idle draining cycle");

endmodule

bind radix_string_to_saturating_integer_core rs2si_checker u_rs2si_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.value)
);

`default_nettype wire
